// ===== rtl/core/point_in_polygon_classifier_core_macros.svh =====
// assertion helpers included by the core back end (ppc_back)
`ifndef POINT_IN_POLYGON_CLASSIFIER_CORE_MACROS_SVH
`define POINT_IN_POLYGON_CLASSIFIER_CORE_MACROS_SVH

// same-cycle implication
`define PPC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppc check failed");

// next-cycle implication
`define PPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppc check failed");

`endif

// ===== rtl/core/ppc_pkg.sv =====
`default_nettype none
package ppc_pkg;
   localparam int MAX_VERTICES = 64;
   localparam int COORD_WIDTH  = 32;
   localparam int FIELD_W      = 32;
   localparam int OPCODE_W     = 2;
   localparam int ANSWER_W     = 2;
   localparam int IDX_W        = $clog2(MAX_VERTICES);
   localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
   localparam int DIFF_W       = COORD_WIDTH + 1;
   localparam int PROD_W       = 2 * DIFF_W;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [OPCODE_W-1:0] {
      OP_START  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2
   } opcode_type;

   typedef enum logic [ANSWER_W-1:0] {
      ANS_INSIDE   = 2'd0,
      ANS_OUTSIDE  = 2'd1,
      ANS_BOUNDARY = 2'd2,
      ANS_DROPPED  = 2'd3
   } answer_type;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      opcode_type op;
      coord_type  x;
      coord_type  y;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } q_wr_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_rd_type;
endpackage
`default_nettype wire

// ===== rtl/core/ppc_if.sv =====
`default_nettype none
interface ppc_req_if import ppc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [OPCODE_W-1:0]        opcode;
   logic signed [FIELD_W-1:0]  coord_x;
   logic signed [FIELD_W-1:0]  coord_y;
   modport source (output valid, opcode, coord_x, coord_y, input ready);
   modport sink (input valid, opcode, coord_x, coord_y, output ready);
endinterface

interface ppc_rsp_if import ppc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ANSWER_W-1:0] answer;
   modport source (output valid, answer, input ready);
   modport sink (input valid, answer, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ppc_front.sv =====
`default_nettype none
module ppc_front import ppc_pkg::*; (
   ppc_req_if.sink  req_chan,
   input  logic     q_full,
   output q_wr_type q_wr
);
   logic keep;

   always_comb begin
      keep = 1'b0;
      unique case (req_chan.opcode)
         OP_START, OP_APPEND, OP_QUERY: keep = 1'b1;
         default: keep = 1'b0;
      endcase
   end

   // unused opcode is taken and dropped here
   assign req_chan.ready = !q_full;
   assign q_wr.push      = req_chan.valid && !q_full && keep;
   assign q_wr.cmd.op    = opcode_type'(req_chan.opcode);
   assign q_wr.cmd.x     = req_chan.coord_x[COORD_WIDTH-1:0];
   assign q_wr.cmd.y     = req_chan.coord_y[COORD_WIDTH-1:0];
endmodule
`default_nettype wire

// ===== rtl/core/ppc_queue.sv =====
`default_nettype none
module ppc_queue import ppc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  q_wr_type q_wr,
   input  logic     q_pop,
   output logic     q_full,
   output q_rd_type q_rd
);
   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_pop;

   assign q_full     = cnt_ff == QCNT_W'(QUEUE_DEPTH);
   assign q_rd.valid = cnt_ff != '0;
   assign q_rd.cmd   = slot_ff[rd_ptr_ff];
   assign do_pop     = q_pop && q_rd.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (q_wr.push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + QCNT_W'(q_wr.push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (q_wr.push) begin
         slot_ff[wr_ptr_ff] <= q_wr.cmd;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/ppc_back.sv =====
`default_nettype none
module ppc_back import ppc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  q_rd_type q_rd,
   output logic     q_pop,
   ppc_rsp_if.source rsp_chan
);
`include "point_in_polygon_classifier_core_macros.svh"

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_QUERY,
      ST_EMIT
   } state_type;

   coord_type mem_x [MAX_VERTICES];
   coord_type mem_y [MAX_VERTICES];

   state_type  state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic       rd_on_ff, rd_on_in;
   coord_type  px_ff, px_in, py_ff, py_in;
   answer_type ans_ff, ans_in;
   logic       bnd_ff, bnd_in, par_ff, par_in;
   logic       rsp_valid_ff, rsp_valid_in;
   answer_type rsp_answer_ff, rsp_answer_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   coord_type        wr_x, wr_y;
   logic             rd_last;
   logic [IDX_W-1:0] rd_addr;

   logic      m_valid_ff, m_first_ff, m_last_ff;
   coord_type m_x_ff, m_y_ff;
   coord_type prev_x_ff, prev_y_ff;

   logic                     e_valid_ff, e_last_ff, e_inbox_ff, e_strad_ff;
   logic                     e_valid_in, e_inbox_in, e_strad_in;
   logic signed [DIFF_W-1:0] d1_ff, d2_ff, d3_ff, d4_ff;
   logic signed [DIFF_W-1:0] d1_in, d2_in, d3_in, d4_in;

   logic                     p_valid_ff, p_last_ff, p_inbox_ff, p_strad_ff;
   logic                     p_dypos_ff, p_dyneg_ff;
   logic signed [PROD_W-1:0] lhs_ff, rhs_ff, lhs_in, rhs_in;

   logic out_free, cross_hit, bnd_hit;

   assign out_free        = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.answer = rsp_answer_ff;
   assign q_pop           = state_ff == ST_IDLE;

   // read sweep covers vertex 0 again to close the polygon
   assign rd_last = rd_idx_ff == count_ff;
   assign rd_addr = rd_last ? '0 : rd_idx_ff[IDX_W-1:0];

   always_comb begin
      coord_type ax, ay, bx, by;
      ax = prev_x_ff;
      ay = prev_y_ff;
      bx = m_x_ff;
      by = m_y_ff;
      e_valid_in = m_valid_ff && !m_first_ff;
      d1_in = DIFF_W'(py_ff) - DIFF_W'(ay);
      d2_in = DIFF_W'(bx) - DIFF_W'(ax);
      d3_in = DIFF_W'(px_ff) - DIFF_W'(ax);
      d4_in = DIFF_W'(by) - DIFF_W'(ay);
      e_inbox_in = (px_ff >= ax || px_ff >= bx) && (px_ff <= ax || px_ff <= bx) &&
                   (py_ff >= ay || py_ff >= by) && (py_ff <= ay || py_ff <= by);
      e_strad_in = (ay > py_ff) != (by > py_ff);
      lhs_in = PROD_W'(d1_ff) * PROD_W'(d2_ff);
      rhs_in = PROD_W'(d3_ff) * PROD_W'(d4_ff);
   end

   assign bnd_hit   = p_valid_ff && p_inbox_ff && (lhs_ff == rhs_ff);
   assign cross_hit = p_valid_ff && p_strad_ff &&
                      ((p_dypos_ff && lhs_ff > rhs_ff) || (p_dyneg_ff && lhs_ff < rhs_ff));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      rd_on_in      = rd_on_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      ans_in        = ans_ff;
      bnd_in        = bnd_ff || bnd_hit;
      par_in        = par_ff ^ cross_hit;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_answer_in = rsp_answer_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[IDX_W-1:0];
      wr_x          = q_rd.cmd.x;
      wr_y          = q_rd.cmd.y;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_rd.valid) begin
               unique case (q_rd.cmd.op)
                  OP_START: begin
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     count_in = CNT_W'(1);
                  end
                  OP_APPEND: begin
                     if (count_ff >= CNT_W'(MAX_VERTICES)) begin
                        ans_in   = ANS_DROPPED;
                        state_in = ST_EMIT;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_QUERY: begin
                     if (count_ff == '0) begin
                        ans_in   = ANS_OUTSIDE;
                        state_in = ST_EMIT;
                     end else begin
                        px_in     = q_rd.cmd.x;
                        py_in     = q_rd.cmd.y;
                        rd_idx_in = '0;
                        rd_on_in  = 1'b1;
                        bnd_in    = 1'b0;
                        par_in    = 1'b0;
                        state_in  = ST_QUERY;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_QUERY: begin
            if (rd_on_ff) begin
               rd_idx_in = rd_idx_ff + 1'b1;
               rd_on_in  = !rd_last;
            end
            if (p_valid_ff && p_last_ff) begin
               ans_in   = (bnd_ff || bnd_hit) ? ANS_BOUNDARY :
                          (par_ff ^ cross_hit) ? ANS_INSIDE : ANS_OUTSIDE;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_answer_in = ans_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[wr_addr] <= wr_x;
         mem_y[wr_addr] <= wr_y;
      end
      if (rd_on_ff) begin
         m_x_ff <= mem_x[rd_addr];
         m_y_ff <= mem_y[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_on_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         m_valid_ff   <= 1'b0;
         e_valid_ff   <= 1'b0;
         p_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_on_ff     <= rd_on_in;
         rsp_valid_ff <= rsp_valid_in;
         m_valid_ff   <= rd_on_ff;
         e_valid_ff   <= e_valid_in;
         p_valid_ff   <= e_valid_ff;
      end
      rd_idx_ff     <= rd_idx_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      ans_ff        <= ans_in;
      bnd_ff        <= bnd_in;
      par_ff        <= par_in;
      rsp_answer_ff <= rsp_answer_in;
      m_first_ff    <= rd_idx_ff == '0;
      m_last_ff     <= rd_last;
      if (m_valid_ff) begin
         prev_x_ff <= m_x_ff;
         prev_y_ff <= m_y_ff;
      end
      e_last_ff  <= m_last_ff;
      e_inbox_ff <= e_inbox_in;
      e_strad_ff <= e_strad_in;
      d1_ff      <= d1_in;
      d2_ff      <= d2_in;
      d3_ff      <= d3_in;
      d4_ff      <= d4_in;
      p_last_ff  <= e_last_ff;
      p_inbox_ff <= e_inbox_ff;
      p_strad_ff <= e_strad_ff;
      p_dypos_ff <= d4_ff > 0;
      p_dyneg_ff <= d4_ff < 0;
      lhs_ff     <= lhs_in;
      rhs_ff     <= rhs_in;
   end

   `PPC_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_VERTICES))
   `PPC_ASSERT_NOW(a_pipe_idle, clock, reset, state_ff != ST_QUERY,
      !(m_valid_ff || e_valid_ff || p_valid_ff || rd_on_ff))
   `PPC_ASSERT_NOW(a_no_write_in_query, clock, reset, wr_en, state_ff == ST_IDLE)
   `PPC_ASSERT_NEXT(a_emit_waits, clock, reset,
      state_ff == ST_EMIT && rsp_valid_ff && !rsp_chan.ready, state_ff == ST_EMIT)
endmodule
`default_nettype wire

// ===== rtl/core/point_in_polygon_classifier_core.sv =====
`default_nettype none
// Point-in-polygon classifier. Beats on the request channel start a polygon, append a vertex
// (up to 64) or query a point; a query returns inside, outside or boundary by even-odd ray
// casting with exact cross-multiplied compares, and an append to a full store returns dropped.
// Requests go into a two-entry queue, so the request side keeps flowing while the back end
// works until the queue fills. A query on n vertices sweeps the vertex memory one read per
// cycle (n+1 reads to close the polygon) through the memory read, edge difference and product
// registers into the answer register and then the output register, where the answer waits
// until the result side takes it.
module point_in_polygon_classifier_core import ppc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ppc_req_if.sink   req_chan,
   ppc_rsp_if.source rsp_chan
);
   q_wr_type q_wr;
   q_rd_type q_rd;
   logic     q_full;
   logic     q_pop;

   ppc_front u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_wr     (q_wr)
   );

   ppc_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_wr   (q_wr),
      .q_pop  (q_pop),
      .q_full (q_full),
      .q_rd   (q_rd)
   );

   ppc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_rd     (q_rd),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );
endmodule
`default_nettype wire
